// ===== hw/rtl/npcc_pkg.sv =====
// package for the nearest palette color classifier
// holds field widths, request codes, candidate and write structs, compare helper
// no dependencies
`timescale 1ns / 1ps

package npcc_pkg;

  localparam int PAL_DEPTH     = 16;
  localparam int IDX_W         = 4;
  localparam int CHAN_W        = 8;
  localparam int COLOR_W       = 3 * CHAN_W;
  localparam int DIST_W        = 10;
  localparam int SGR_W         = 7;
  localparam int ALPHA_OUT_W   = 3;
  localparam int CHAN_MAX      = 255;
  localparam int SGR_LOW_BASE  = 30;
  localparam int SGR_HIGH_BASE = 82;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0] dsum;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } pal_wr_t;

  // keeps the lower-index candidate unless the other is strictly closer
  function automatic cand_t pick_lower(input cand_t lo, input cand_t hi);
    pick_lower = (hi.dsum < lo.dsum) ? hi : lo;
  endfunction

endpackage

// ===== hw/rtl/npcc_palette.sv =====
// palette storage and one l1 distance lane per entry
// depends on npcc_pkg
`timescale 1ns / 1ps

module npcc_palette (
  input  logic                    clk_i,
  input  npcc_pkg::pal_wr_t       wr_i,
  input  logic [7:0]              red_i,
  input  logic [7:0]              green_i,
  input  logic [7:0]              blue_i,
  output logic [9:0]              dist_o [16]
);
  import npcc_pkg::*;

  logic [COLOR_W-1:0] pal_q [PAL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pal_q[wr_i.idx] <= wr_i.color;
    end
  end

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  for (genvar i = 0; i < PAL_DEPTH; i++) begin : g_lane
    logic [CHAN_W-1:0] dr, dg, db;
    assign dr = abs_diff(red_i,   pal_q[i][23:16]);
    assign dg = abs_diff(green_i, pal_q[i][15:8]);
    assign db = abs_diff(blue_i,  pal_q[i][7:0]);
    assign dist_o[i] = {2'b00, dr} + {2'b00, dg} + {2'b00, db};
  end

endmodule

// ===== hw/rtl/npcc_argmin4.sv =====
// two-level compare tree, four candidates down to one, lowest index on ties
// depends on npcc_pkg
`timescale 1ns / 1ps

module npcc_argmin4 (
  input  npcc_pkg::cand_t cand_i [4],
  output npcc_pkg::cand_t best_o
);
  import npcc_pkg::*;

  cand_t left, right;

  assign left   = pick_lower(cand_i[0], cand_i[1]);
  assign right  = pick_lower(cand_i[2], cand_i[3]);
  assign best_o = pick_lower(left, right);

endmodule

// ===== hw/rtl/npcc_alpha_quant.sv =====
// alpha quantizer: rounded level by constant thresholds, clamped to the top level
// depends on npcc_pkg
`timescale 1ns / 1ps

module npcc_alpha_quant #(
  parameter int ALPHA_LEVELS = 8
) (
  input  logic [7:0]                        alpha_i,
  output logic [$clog2(ALPHA_LEVELS)-1:0]   level_o
);
  import npcc_pkg::*;

  localparam int LVL_W    = $clog2(ALPHA_LEVELS);
  localparam int STEP_RAW = CHAN_MAX / ALPHA_LEVELS;
  localparam int STEP     = (STEP_RAW == 0) ? 1 : STEP_RAW;
  localparam int HALF     = STEP / 2;
  localparam int TOP      = ALPHA_LEVELS - 1;

  always_comb begin
    level_o = '0;
    if (int'(alpha_i) > CHAN_MAX - HALF) begin
      level_o = LVL_W'(TOP);
    end else begin
      // thresholds rise with k, so the last one passed is the level
      for (int k = 1; k <= TOP; k++) begin
        if ({2'b00, alpha_i} >= 10'(k * STEP - HALF)) begin
          level_o = LVL_W'(k);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/nearest_palette_color_classifier.sv =====
// top level of the nearest palette color classifier
// depends on npcc_pkg, npcc_palette, npcc_argmin4, npcc_alpha_quant
`timescale 1ns / 1ps

// Classifies RGBA pixels against a 16-entry palette loaded by write transactions.
// A write transaction (req_type 0) stores red/green/blue at entry_index and gives no
// result; a classify transaction (req_type 1) gives one result: the nearest entry by
// sum of absolute channel differences (lowest index on a tie), that distance, its
// terminal color code, and alpha quantized to ALPHA_LEVELS levels (low 3 bits).
// The pipeline takes one transaction per clock and has three register stages: the
// sixteen distance lanes, a 16-to-4 compare tree, and a 4-to-1 compare tree that
// feeds the output register; only a held-off result stalls the input.
// The palette is read at acceptance, so a write is seen by every later pixel.
// Entries never written since reset hold arbitrary values; load all sixteen first.

module nearest_palette_color_classifier #(
  parameter int ALPHA_LEVELS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [3:0] entry_index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] alpha_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] palette_index_o,
  output logic [9:0] distance_o,
  output logic [6:0] sgr_code_o,
  output logic [2:0] alpha_level_o
);
  import npcc_pkg::*;

  localparam int LVL_W = $clog2(ALPHA_LEVELS);

  // stage advance: a stage moves when it is empty or the next one moves
  logic s1_adv, s2_adv, s3_adv;
  logic in_acc;

  // stage 1: per-entry distances and alpha level
  logic              s1_valid_q;
  logic [DIST_W-1:0] s1_dist_q [PAL_DEPTH];
  logic [LVL_W-1:0]  s1_lvl_q;

  // stage 2: four winners of the first tree half
  logic              s2_valid_q;
  cand_t             s2_cand_q [4];
  logic [LVL_W-1:0]  s2_lvl_q;

  // stage 3: output register
  logic              s3_valid_q;
  logic [IDX_W-1:0]  s3_idx_q;
  logic [DIST_W-1:0] s3_dist_q;
  logic [SGR_W-1:0]  s3_sgr_q;
  logic [2:0]        s3_alpha_q;

  assign s3_adv     = !s3_valid_q || out_ready_i;
  assign s2_adv     = !s2_valid_q || s3_adv;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // palette write and distance lanes, read at acceptance
  pal_wr_t           pal_wr;
  logic [DIST_W-1:0] lane_dist [PAL_DEPTH];
  logic [LVL_W-1:0]  lvl_d;

  assign pal_wr.en    = in_acc && (req_type_i == REQ_WRITE);
  assign pal_wr.idx   = entry_index_i;
  assign pal_wr.color = {red_i, green_i, blue_i};

  npcc_palette u_palette (
    .clk_i   (clk_i),
    .wr_i    (pal_wr),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .dist_o  (lane_dist)
  );

  npcc_alpha_quant #(
    .ALPHA_LEVELS (ALPHA_LEVELS)
  ) u_alpha_quant (
    .alpha_i (alpha_i),
    .level_o (lvl_d)
  );

  // first tree half: four groups of four lanes
  cand_t grp_best [4];

  for (genvar g = 0; g < 4; g++) begin : g_grp
    cand_t grp_cand [4];
    for (genvar j = 0; j < 4; j++) begin : g_cand
      assign grp_cand[j].dsum = s1_dist_q[4*g+j];
      assign grp_cand[j].idx  = IDX_W'(4*g+j);
    end
    npcc_argmin4 u_argmin (
      .cand_i (grp_cand),
      .best_o (grp_best[g])
    );
  end

  // second tree half and terminal color code
  cand_t            fin_best;
  logic [SGR_W-1:0] sgr_d;

  npcc_argmin4 u_argmin_fin (
    .cand_i (s2_cand_q),
    .best_o (fin_best)
  );

  // entries 0..7 map to the normal colors, 8..15 to the bright ones
  assign sgr_d = fin_best.idx[IDX_W-1]
               ? (SGR_W'(fin_best.idx) + SGR_W'(SGR_HIGH_BASE))
               : (SGR_W'(fin_best.idx) + SGR_W'(SGR_LOW_BASE));

  // valid bits travel with the data; a write enters stage 1 as an empty slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_acc && (req_type_i == REQ_CLASSIFY);
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_adv) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_dist_q <= lane_dist;
      s1_lvl_q  <= lvl_d;
    end
    if (s2_adv) begin
      s2_cand_q <= grp_best;
      s2_lvl_q  <= s1_lvl_q;
    end
    if (s3_adv) begin
      s3_idx_q   <= fin_best.idx;
      s3_dist_q  <= fin_best.dsum;
      s3_sgr_q   <= sgr_d;
      s3_alpha_q <= ALPHA_OUT_W'(s2_lvl_q);
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign palette_index_o = s3_idx_q;
  assign distance_o      = s3_dist_q;
  assign sgr_code_o      = s3_sgr_q;
  assign alpha_level_o   = s3_alpha_q;

endmodule
